[hw/rtl/qvr_pkg.sv]
// Shared constants for the quaternion vector rotation pipeline.
`default_nettype none

package qvr_pkg;

   localparam int COMPONENT_WIDTH_DEFAULT = 16;

   localparam logic signed [63:0] OP_MAX = 64'sd2147483647;
   localparam logic signed [63:0] OP_MIN = -64'sd2147483648;

endpackage

`default_nettype wire

[hw/rtl/quaternion_vector_rotate.sv]
// Pipelined quaternion vector rotation with normalisation to unit length.
// The pipeline has six arithmetic stages, one square-root stage per result bit, the divider
// set-up stage, one divider stage per quotient bit and the output register. Throughput is
// one word per cycle; the whole pipeline holds while a finished word waits at the output.
// Reset clears only the valid bits.
`default_nettype none

module quaternion_vector_rotate #(
   parameter int COMPONENT_WIDTH = qvr_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_w,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_vec_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_vec_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_vec_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_out_x,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_out_y,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_out_z,
   output logic                              rsp_zero_length
);
   import qvr_pkg::*;

   localparam int W    = COMPONENT_WIDTH;
   localparam int FRAC = W - 2;
   localparam int P1W  = W + 2;
   localparam int FW   = (W + 4 < 32) ? W + 4 : 32;
   localparam int PW   = W + 6;
   localparam int RW   = (W + 6 < 32) ? W + 6 : 32;
   localparam int SW   = 2 * RW;
   localparam int LW   = RW;
   localparam int QW   = W - 1;
   localparam int NW   = RW + FRAC + 1;
   localparam int NST  = 8 + LW + QW;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
      rnd = (p + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                  input logic signed [63:0] lo,
                                                  input logic signed [63:0] hi);
      if (v < lo) begin
         clamp64 = lo;
      end else if (v > hi) begin
         clamp64 = hi;
      end else begin
         clamp64 = v;
      end
   endfunction

   logic           adv;
   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;

   assign adv       = !v_ff[NST-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = v_ff[NST-1];
   assign v_in      = {v_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // Stage 0: quaternion products.
   logic signed [P1W-1:0] p1_ff [0:9];
   logic signed [P1W-1:0] p1_in [0:9];
   logic signed [W-1:0]   vec0_ff [0:2];
   logic signed [W-1:0]   vec0_in [0:2];
   logic signed [W-1:0]   qa [0:9];
   logic signed [W-1:0]   qb [0:9];

   always_comb begin
      qa[0] = req_quat_w; qb[0] = req_quat_w;
      qa[1] = req_quat_x; qb[1] = req_quat_x;
      qa[2] = req_quat_y; qb[2] = req_quat_y;
      qa[3] = req_quat_z; qb[3] = req_quat_z;
      qa[4] = req_quat_x; qb[4] = req_quat_y;
      qa[5] = req_quat_w; qb[5] = req_quat_z;
      qa[6] = req_quat_x; qb[6] = req_quat_z;
      qa[7] = req_quat_w; qb[7] = req_quat_y;
      qa[8] = req_quat_y; qb[8] = req_quat_z;
      qa[9] = req_quat_w; qb[9] = req_quat_x;
      vec0_in[0] = req_vec_x;
      vec0_in[1] = req_vec_y;
      vec0_in[2] = req_vec_z;
   end

   for (genvar i = 0; i < 10; i++) begin : g_p1
      logic signed [2*W-1:0] prod;
      assign prod     = qa[i] * qb[i];
      assign p1_in[i] = P1W'(rnd(64'(prod)));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff   <= p1_in;
         vec0_ff <= vec0_in;
      end
   end

   // Stage 1: matrix factors.
   logic signed [63:0]   s1 [0:8];
   logic signed [FW-1:0] f_ff [0:8];
   logic signed [FW-1:0] f_in [0:8];
   logic signed [W-1:0]  vec1_ff [0:2];

   always_comb begin
      s1[0] = 64'(p1_ff[0]) + 64'(p1_ff[1]) - 64'(p1_ff[2]) - 64'(p1_ff[3]);
      s1[1] = 64'(p1_ff[4]) + 64'(p1_ff[5]);
      s1[2] = 64'(p1_ff[6]) - 64'(p1_ff[7]);
      s1[3] = 64'(p1_ff[0]) - 64'(p1_ff[1]) + 64'(p1_ff[2]) - 64'(p1_ff[3]);
      s1[4] = 64'(p1_ff[4]) - 64'(p1_ff[5]);
      s1[5] = 64'(p1_ff[8]) + 64'(p1_ff[9]);
      s1[6] = 64'(p1_ff[0]) - 64'(p1_ff[1]) - 64'(p1_ff[2]) + 64'(p1_ff[3]);
      s1[7] = 64'(p1_ff[6]) + 64'(p1_ff[7]);
      s1[8] = 64'(p1_ff[8]) - 64'(p1_ff[9]);
      for (int i = 0; i < 9; i++) begin
         f_in[i] = FW'(clamp64(s1[i], OP_MIN, OP_MAX));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff    <= f_in;
         vec1_ff <= vec0_ff;
      end
   end

   // Stage 2: factor times vector component.
   logic signed [W-1:0]  mv [0:8];
   logic signed [PW-1:0] p2_ff [0:8];
   logic signed [PW-1:0] p2_in [0:8];

   always_comb begin
      mv[0] = vec1_ff[0]; mv[1] = vec1_ff[1]; mv[2] = vec1_ff[2];
      mv[3] = vec1_ff[1]; mv[4] = vec1_ff[0]; mv[5] = vec1_ff[2];
      mv[6] = vec1_ff[2]; mv[7] = vec1_ff[0]; mv[8] = vec1_ff[1];
   end

   for (genvar i = 0; i < 9; i++) begin : g_p2
      logic signed [FW+W-1:0] prod;
      assign prod     = f_ff[i] * mv[i];
      assign p2_in[i] = PW'(rnd(64'(prod)));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_ff <= p2_in;
      end
   end

   // Stage 3: rotated components.
   logic signed [RW-1:0] r3_ff [0:2];
   logic signed [RW-1:0] r3_in [0:2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         r3_in[c] = RW'(clamp64(64'(p2_ff[3*c]) + 64'sd2 * (64'(p2_ff[3*c+1])
                    + 64'(p2_ff[3*c+2])), -OP_MAX, OP_MAX));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r3_ff <= r3_in;
      end
   end

   // Stage 4: squares. Stage 5: squared length.
   logic [SW-1:0]        sqr_ff [0:2];
   logic [SW-1:0]        sqr_in [0:2];
   logic signed [RW-1:0] r4_ff [0:2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sqr_in[c] = SW'(r3_ff[c] * r3_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqr_ff <= sqr_in;
         r4_ff  <= r3_ff;
      end
   end

   logic [SW-1:0]        sq_rem_ff  [0:LW];
   logic [LW-1:0]        sq_root_ff [0:LW];
   logic signed [RW-1:0] sq_r_ff    [0:LW][0:2];
   logic [SW-1:0]        sq_rem_in0;

   assign sq_rem_in0 = sqr_ff[0] + sqr_ff[1] + sqr_ff[2];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= sq_rem_in0;
         sq_root_ff[0] <= '0;
         sq_r_ff[0]    <= r4_ff;
      end
   end

   // Square root, one result bit per stage, most significant first.
   for (genvar j = 1; j <= LW; j++) begin : g_sqrt
      localparam int K = LW - j;
      logic [SW:0]   trial;
      logic [SW-1:0] rem_in;
      logic [LW-1:0] root_in;

      always_comb begin
         trial = ((SW+1)'(sq_root_ff[j-1]) << (K + 1)) + ((SW+1)'(1) << (2 * K));
         if ((SW+1)'(sq_rem_ff[j-1]) >= trial) begin
            rem_in  = SW'((SW+1)'(sq_rem_ff[j-1]) - trial);
            root_in = sq_root_ff[j-1] | (LW'(1) << K);
         end else begin
            rem_in  = sq_rem_ff[j-1];
            root_in = sq_root_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[j]  <= rem_in;
            sq_root_ff[j] <= root_in;
            sq_r_ff[j]    <= sq_r_ff[j-1];
         end
      end
   end

   // Divider set-up: rounded dividend, top part as first remainder.
   logic [RW-1:0] dv_rem_ff [0:QW][0:2];
   logic [QW-1:0] dv_lo_ff  [0:QW][0:2];
   logic [QW-1:0] dv_q_ff   [0:QW][0:2];
   logic          dv_neg_ff [0:QW][0:2];
   logic [LW-1:0] dv_len_ff [0:QW];
   logic [LW-1:0] len;

   assign len = sq_root_ff[LW];

   for (genvar c = 0; c < 3; c++) begin : g_prep
      logic [RW-1:0] mag;
      logic [NW-1:0] num;

      always_comb begin
         mag = sq_r_ff[LW][c][RW-1] ? RW'(-sq_r_ff[LW][c]) : RW'(sq_r_ff[LW][c]);
         num = (NW'(mag) << FRAC) + NW'(len >> 1);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[0][c] <= num[NW-1:QW];
            dv_lo_ff[0][c]  <= num[QW-1:0];
            dv_q_ff[0][c]   <= '0;
            dv_neg_ff[0][c] <= sq_r_ff[LW][c][RW-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_len_ff[0] <= len;
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar j = 1; j <= QW; j++) begin : g_div
      for (genvar c = 0; c < 3; c++) begin : g_lane
         logic [RW:0]   t;
         logic [RW-1:0] rem_in;
         logic [QW-1:0] q_in;

         always_comb begin
            t = {dv_rem_ff[j-1][c], dv_lo_ff[j-1][c][QW-1]};
            if (t >= (RW+1)'(dv_len_ff[j-1])) begin
               rem_in = RW'(t - (RW+1)'(dv_len_ff[j-1]));
               q_in   = {dv_q_ff[j-1][c][QW-2:0], 1'b1};
            end else begin
               rem_in = RW'(t);
               q_in   = {dv_q_ff[j-1][c][QW-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[j][c] <= rem_in;
               dv_lo_ff[j][c]  <= dv_lo_ff[j-1][c] << 1;
               dv_q_ff[j][c]   <= q_in;
               dv_neg_ff[j][c] <= dv_neg_ff[j-1][c];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_len_ff[j] <= dv_len_ff[j-1];
         end
      end
   end

   // Output register: sign restored, zero length passed through as zero.
   logic signed [W-1:0] out_ff [0:2];
   logic signed [W-1:0] out_in [0:2];
   logic                zero_ff;
   logic                zero_in;

   always_comb begin
      zero_in = (dv_len_ff[QW] == '0);
      for (int c = 0; c < 3; c++) begin
         if (zero_in) begin
            out_in[c] = '0;
         end else if (dv_neg_ff[QW][c]) begin
            out_in[c] = -$signed(W'(dv_q_ff[QW][c]));
         end else begin
            out_in[c] = $signed(W'(dv_q_ff[QW][c]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff  <= out_in;
         zero_ff <= zero_in;
      end
   end

   assign rsp_out_x       = out_ff[0];
   assign rsp_out_y       = out_ff[1];
   assign rsp_out_z       = out_ff[2];
   assign rsp_zero_length = zero_ff;

endmodule

`default_nettype wire

[test/tb_quaternion_vector_rotate.sv]
// Self-checking testbench for the normalising quaternion vector rotation pipeline.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate;

   localparam int CW = qvr_pkg::COMPONENT_WIDTH_DEFAULT;
   localparam int FRAC = CW - 2;
   localparam int LATENCY = 45;

   typedef logic signed [CW-1:0] comp_type;

   typedef struct packed {
      comp_type rx;
      comp_type ry;
      comp_type rz;
      logic     zero;
   } unit_vec_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   comp_type req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   comp_type req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   comp_type rsp_out_x, rsp_out_y, rsp_out_z;
   logic     rsp_zero_length;

   unit_vec_type expected_vecs[$];
   int           error_count = 0;
   int           burst_left = 0;
   logic         stall_enable = 1'b1;

   quaternion_vector_rotate #(.COMPONENT_WIDTH(CW)) dut (.*);

   always #10 clock = ~clock;

   initial begin
      #100ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic longint fx_mul(longint a, longint b);
      longint p;
      p = a * b + (longint'(1) << (FRAC - 1));
      return p >>> FRAC;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = longint'(1) << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic comp_type to_unit(longint r, longint unsigned len);
      longint unsigned mag, q;
      longint s;
      mag = r < 0 ? -r : r;
      q = ((mag << FRAC) + len / 2) / len;
      if (q > (longint'(1) << CW)) q = longint'(1) << CW;
      s = r < 0 ? -longint'(q) : longint'(q);
      if (s > (longint'(1) << (CW - 1)) - 1) s = (longint'(1) << (CW - 1)) - 1;
      if (s < -(longint'(1) << (CW - 1))) s = -(longint'(1) << (CW - 1));
      return comp_type'(s);
   endfunction

   function automatic unit_vec_type rotate_normalise(comp_type qw, comp_type qx,
                                                     comp_type qy, comp_type qz,
                                                     comp_type vx, comp_type vy,
                                                     comp_type vz);
      longint a, b, c, d, x, y, z, aa, bb, cc, dd, bc, ad, bd, ac, cd, ab, rx, ry, rz;
      longint unsigned s2, len;
      unit_vec_type u;
      a = qw; b = qx; c = qy; d = qz; x = vx; y = vy; z = vz;
      aa = fx_mul(a, a); bb = fx_mul(b, b); cc = fx_mul(c, c); dd = fx_mul(d, d);
      bc = fx_mul(b, c); ad = fx_mul(a, d); bd = fx_mul(b, d);
      ac = fx_mul(a, c); cd = fx_mul(c, d); ab = fx_mul(a, b);
      rx = fx_mul(aa + bb - cc - dd, x) + 2 * (fx_mul(bc + ad, y) + fx_mul(bd - ac, z));
      ry = fx_mul(aa - bb + cc - dd, y) + 2 * (fx_mul(bc - ad, x) + fx_mul(cd + ab, z));
      rz = fx_mul(aa - bb - cc + dd, z) + 2 * (fx_mul(bd + ac, x) + fx_mul(cd - ab, y));
      s2 = rx * rx + ry * ry + rz * rz;
      if (s2 == 0) begin
         u = '{rx: '0, ry: '0, rz: '0, zero: 1'b1};
      end else begin
         len = int_sqrt(s2);
         u = '{rx: to_unit(rx, len), ry: to_unit(ry, len), rz: to_unit(rz, len), zero: 1'b0};
      end
      return u;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   task automatic send_word(comp_type qw, comp_type qx, comp_type qy, comp_type qz,
                            comp_type vx, comp_type vy, comp_type vz);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_quat_w <= qw; req_quat_x <= qx; req_quat_y <= qy; req_quat_z <= qz;
      req_vec_x <= vx; req_vec_y <= vy; req_vec_z <= vz;
      expected_vecs.push_back(rotate_normalise(qw, qx, qy, qz, vx, vy, vz));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      idle_sender();
      while (expected_vecs.size() != 0) @(posedge clock);
   endtask

   function automatic comp_type rand_comp();
      case ($urandom_range(0, 5))
         0: return comp_type'(16'sh7FFF);
         1: return comp_type'(16'sh8000);
         2: return '0;
         3: return comp_type'($urandom_range(0, 32768) - 16384);
         default: return comp_type'($urandom);
      endcase
   endfunction

   // Unit quaternions of random direction.
   task automatic send_unit_rotation();
      real w, x, y, z, n;
      w = $urandom_range(0, 2000) - 1000.0; x = $urandom_range(0, 2000) - 1000.0;
      y = $urandom_range(0, 2000) - 1000.0; z = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(w * w + x * x + y * y + z * z);
      if (n == 0.0) begin
         w = 1.0; n = 1.0;
      end
      send_word(comp_type'($rtoi(w / n * 16384.0)), comp_type'($rtoi(x / n * 16384.0)),
                comp_type'($rtoi(y / n * 16384.0)), comp_type'($rtoi(z / n * 16384.0)),
                rand_comp(), rand_comp(), rand_comp());
   endtask

   task automatic test_directed();
      comp_type one, mx, mn;
      one = comp_type'(16384); mx = comp_type'(16'sh7FFF); mn = comp_type'(16'sh8000);
      send_word(one, 0, 0, 0, one, 0, 0);
      send_word(one, 0, 0, 0, 0, 0, 0);
      send_word(0, 0, 0, 0, one, one, one);
      send_word(0, one, 0, 0, 0, one, 0);
      send_word(0, 0, one, 0, 0, 0, one);
      send_word(0, 0, 0, one, one, 0, 0);
      send_word(mx, mx, mx, mx, mx, mx, mx);
      send_word(mn, mn, mn, mn, mn, mn, mn);
      send_word(mx, mn, mx, mn, mn, mx, mn);
      send_word(mn, 0, 0, 0, mn, 0, mx);
      send_word(comp_type'(11585), comp_type'(11585), 0, 0, 0, one, 0);
      send_word(comp_type'(8192), comp_type'(8192), comp_type'(8192), comp_type'(8192),
                one, 0, 0);
      send_word(comp_type'(100), 0, 0, 0, one, one, 0);
      send_word(comp_type'(1), comp_type'(-1), comp_type'(1), comp_type'(-1),
                comp_type'(1), 0, 0);
      send_word(one, 0, 0, 0, comp_type'(1), comp_type'(-1), 0);
      send_word(mx, 0, 0, 0, 0, 0, mn);
      send_word(comp_type'(-16384), 0, 0, 0, 0, comp_type'(-1), 0);
      drain();
   endtask

   task automatic test_unit_rotations(int n);
      repeat (n) send_unit_rotation();
      drain();
   endtask

   task automatic test_random_fields(int n);
      repeat (n) begin
         if ($urandom_range(0, 9) == 0)
            send_word(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 0, 0, 0);
         else
            send_word(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                      rand_comp(), rand_comp(), rand_comp());
      end
      drain();
   endtask

   task automatic test_no_stall(int n);
      stall_enable = 1'b0;
      burst_left = n;
      repeat (n) send_unit_rotation();
      drain();
      stall_enable = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else if (!stall_enable)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(0, 15) < 11);
   end

   always @(posedge clock) begin
      unit_vec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_vecs.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = expected_vecs.pop_front();
            if (rsp_out_x !== want.rx) report_mismatch("out_x", rsp_out_x, want.rx);
            if (rsp_out_y !== want.ry) report_mismatch("out_y", rsp_out_y, want.ry);
            if (rsp_out_z !== want.rz) report_mismatch("out_z", rsp_out_z, want.rz);
            if (rsp_zero_length !== want.zero)
               report_mismatch("zero_length", rsp_zero_length, want.zero);
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_unit_rotations(700);
      test_random_fields(700);
      test_no_stall(150);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
